[rtl/eight_bit_cpu_alu_with_flags_macros.svh]
// ----------------------------------------------------------------------------
// ALU assertion macros
// Shared concurrent assertion forms for the 8-bit CPU ALU.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ALU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alu assertion failed");

// antecedent implies consequent in the next cycle
`define ALU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alu assertion failed");

`endif

[rtl/ebcalu_pkg.sv]
// ----------------------------------------------------------------------------
// ALU package
// Operation codes and item types of the 8-bit CPU ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package ebcalu_pkg;

   localparam int unsigned WORD_W   = 16;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned NIBBLE_W = 4;

   typedef enum logic [2:0] {
      OP_ADD8     = 3'd0,
      OP_SUB8     = 3'd1,
      OP_ADD16_LO = 3'd2,
      OP_ADD16_HI = 3'd3,
      OP_SHIFT    = 3'd4,
      OP_SRA      = 3'd5,
      OP_ROTATE   = 3'd6,
      OP_ROT_CARRY = 3'd7
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   operand_a;
      logic [WORD_W-1:0]   operand_b;
      logic                carry_in;
      logic                direction;
   } req_item_type;

   typedef struct packed {
      logic [WORD_W-1:0]   value;
      logic                flag_zero;
      logic                flag_subtract;
      logic                flag_half_carry;
      logic                flag_carry;
   } rsp_item_type;

endpackage

`default_nettype wire

[rtl/eight_bit_cpu_alu_with_flags.sv]
// ----------------------------------------------------------------------------
// 8-bit CPU ALU with flags
// Add, subtract, 16-bit add, shifts and rotates with Z, N, H and C flags.
// A request is registered in the input stage, then its result in the result register once the output is free.
// Throughput: one request per cycle while the result side does not stall, set by the input and result registers.
// Stall on the result side holds both stages and propagates to req_stall.
// Reset clears the two stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "eight_bit_cpu_alu_with_flags_macros.svh"

module eight_bit_cpu_alu_with_flags
   import ebcalu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [2:0]          req_type,
   input  wire logic [WORD_W-1:0]   req_operand_a,
   input  wire logic [WORD_W-1:0]   req_operand_b,
   input  wire logic                req_carry_in,
   input  wire logic                req_direction,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [WORD_W-1:0]   rsp_value,
   output      logic                rsp_flag_zero,
   output      logic                rsp_flag_subtract,
   output      logic                rsp_flag_half_carry,
   output      logic                rsp_flag_carry
);

   req_item_type req_ff, req_in;
   logic         s1_valid_ff, s1_valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         req_accept;
   logic         out_free;
   logic         advance;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign advance    = s1_valid_ff & out_free;
   assign req_stall  = s1_valid_ff & ~out_free;
   assign req_accept = req_valid & ~req_stall;

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

   always_comb begin
      req_in           = req_ff;
      req_in.op        = op_type'(req_type);
      req_in.operand_a = req_operand_a;
      req_in.operand_b = req_operand_b;
      req_in.carry_in  = req_carry_in;
      req_in.direction = req_direction;
   end

   // operation datapath
   always_comb begin
      logic [BYTE_W-1:0]   a8;
      logic [NIBBLE_W:0]   nib_lo;
      logic [NIBBLE_W:0]   nib_hi;
      logic [BYTE_W:0]     byte_sum;
      logic [NIBBLE_W:0]   mid_nib;
      logic [NIBBLE_W:0]   top_nib;
      logic [WORD_W-1:0]   wide_sum;
      logic [WORD_W-1:0]   value;
      logic                flag_n;
      logic                flag_h;
      logic                flag_c;

      a8       = req_ff.operand_a[BYTE_W-1:0];
      nib_lo   = '0;
      nib_hi   = '0;
      byte_sum = {1'b0, req_ff.operand_a[BYTE_W-1:0]}
               + {1'b0, req_ff.operand_b[BYTE_W-1:0]};
      mid_nib  = {1'b0, req_ff.operand_a[11:8]} + {1'b0, req_ff.operand_b[11:8]}
               + {{NIBBLE_W{1'b0}}, byte_sum[BYTE_W]};
      top_nib  = {1'b0, req_ff.operand_a[15:12]} + {1'b0, req_ff.operand_b[15:12]}
               + {{NIBBLE_W{1'b0}}, mid_nib[NIBBLE_W]};
      wide_sum = req_ff.operand_a + req_ff.operand_b;
      value    = '0;
      flag_n   = 1'b0;
      flag_h   = 1'b0;
      flag_c   = 1'b0;

      case (req_ff.op)
         OP_ADD8: begin
            nib_lo = {1'b0, a8[3:0]} + {1'b0, req_ff.operand_b[3:0]}
                   + {{NIBBLE_W{1'b0}}, req_ff.carry_in};
            nib_hi = {1'b0, a8[7:4]} + {1'b0, req_ff.operand_b[7:4]}
                   + {{NIBBLE_W{1'b0}}, nib_lo[NIBBLE_W]};
            value  = {{BYTE_W{1'b0}}, nib_hi[3:0], nib_lo[3:0]};
            flag_h = nib_lo[NIBBLE_W];
            flag_c = nib_hi[NIBBLE_W];
         end
         OP_SUB8: begin
            nib_lo = {1'b0, a8[3:0]} - {1'b0, req_ff.operand_b[3:0]}
                   - {{NIBBLE_W{1'b0}}, req_ff.carry_in};
            nib_hi = {1'b0, a8[7:4]} - {1'b0, req_ff.operand_b[7:4]}
                   - {{NIBBLE_W{1'b0}}, nib_lo[NIBBLE_W]};
            value  = {{BYTE_W{1'b0}}, nib_hi[3:0], nib_lo[3:0]};
            flag_n = 1'b1;
            flag_h = nib_lo[NIBBLE_W];
            flag_c = nib_hi[NIBBLE_W];
         end
         OP_ADD16_LO: begin
            nib_lo = {1'b0, a8[3:0]} + {1'b0, req_ff.operand_b[3:0]};
            value  = wide_sum;
            flag_h = nib_lo[NIBBLE_W];
            flag_c = byte_sum[BYTE_W];
         end
         OP_ADD16_HI: begin
            value  = wide_sum;
            flag_h = mid_nib[NIBBLE_W];
            flag_c = top_nib[NIBBLE_W];
         end
         OP_SHIFT: begin
            if (req_ff.direction) begin
               value  = {{BYTE_W{1'b0}}, 1'b0, a8[7:1]};
               flag_c = a8[0];
            end else begin
               value  = {{BYTE_W{1'b0}}, a8[6:0], 1'b0};
               flag_c = a8[7];
            end
         end
         OP_SRA: begin
            value  = {{BYTE_W{1'b0}}, a8[7], a8[7:1]};
            flag_c = a8[0];
         end
         OP_ROTATE: begin
            if (req_ff.direction) begin
               value  = {{BYTE_W{1'b0}}, a8[0], a8[7:1]};
               flag_c = a8[0];
            end else begin
               value  = {{BYTE_W{1'b0}}, a8[6:0], a8[7]};
               flag_c = a8[7];
            end
         end
         OP_ROT_CARRY: begin
            if (req_ff.direction) begin
               value  = {{BYTE_W{1'b0}}, req_ff.carry_in, a8[7:1]};
               flag_c = a8[0];
            end else begin
               value  = {{BYTE_W{1'b0}}, a8[6:0], req_ff.carry_in};
               flag_c = a8[7];
            end
         end
         default: begin
            value  = '0;
            flag_c = 1'b0;
         end
      endcase

      rsp_in.value           = value;
      rsp_in.flag_zero       = (value == '0);
      rsp_in.flag_subtract   = flag_n;
      rsp_in.flag_half_carry = flag_h;
      rsp_in.flag_carry      = flag_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_value           = rsp_ff.value;
   assign rsp_flag_zero       = rsp_ff.flag_zero;
   assign rsp_flag_subtract   = rsp_ff.flag_subtract;
   assign rsp_flag_half_carry = rsp_ff.flag_half_carry;
   assign rsp_flag_carry      = rsp_ff.flag_carry;

   // held request stays in the input stage
   `ALU_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

   // a request leaving the input stage shows up as a result
   `ALU_ASSERT_NEXT(a_s1_to_rsp, clock, reset, advance, rsp_valid_ff)

   // only subtraction sets the subtract flag
   `ALU_ASSERT_NEXT(a_sub_only, clock, reset,
      advance && (req_ff.op != OP_SUB8), !rsp_flag_subtract)

   // shifts and rotates never set half carry
   `ALU_ASSERT_NEXT(a_shift_no_h, clock, reset,
      advance && (req_ff.op == OP_SHIFT || req_ff.op == OP_SRA ||
                  req_ff.op == OP_ROTATE || req_ff.op == OP_ROT_CARRY),
      !rsp_flag_half_carry)

   // zero flag agrees with the held result
   `ALU_ASSERT_NOW(a_zero_flag, clock, reset, rsp_valid_ff,
      rsp_flag_zero == (rsp_value == '0))

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// 8-bit CPU ALU testbench
// Feeds directed corner cases and random operations through the request
// channel with bursty traffic and a stalling receiver, computes the expected
// value and Z, N, H, C flags for each accepted request and checks every
// result in order.
// ----------------------------------------------------------------------------

module tb;
   import ebcalu_pkg::*;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_kind;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_type = OP_ADD8;
   logic [WORD_W-1:0]   req_operand_a = '0;
   logic [WORD_W-1:0]   req_operand_b = '0;
   logic                req_carry_in = 1'b0;
   logic                req_direction = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [WORD_W-1:0]   rsp_value;
   logic                rsp_flag_zero;
   logic                rsp_flag_subtract;
   logic                rsp_flag_half_carry;
   logic                rsp_flag_carry;

   req_item_type  alu_requests[$];
   rsp_item_type  predicted_results[$];
   req_item_type  driven_req;
   req_item_type  next_req;
   rsp_item_type  want_rsp;
   rsp_item_type  got_rsp;
   int unsigned   burst_left = 0;
   int unsigned   gap_left = 0;
   stall_kind     stall_mode = STALL_NONE;
   int unsigned   mode_left = 0;
   int unsigned   fail_count = 0;

   eight_bit_cpu_alu_with_flags dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_operand_a       (req_operand_a),
      .req_operand_b       (req_operand_b),
      .req_carry_in        (req_carry_in),
      .req_direction       (req_direction),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value           (rsp_value),
      .rsp_flag_zero       (rsp_flag_zero),
      .rsp_flag_subtract   (rsp_flag_subtract),
      .rsp_flag_half_carry (rsp_flag_half_carry),
      .rsp_flag_carry      (rsp_flag_carry)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_item_type alu_compute(req_item_type r);
      rsp_item_type        res;
      logic [4:0]          lo;
      logic [4:0]          hi;
      logic [8:0]          byte_sum;
      logic [WORD_W:0]     word_sum;
      logic [BYTE_W-1:0]   a8;
      res = '0;
      lo = '0;
      hi = '0;
      a8 = r.operand_a[7:0];
      byte_sum = {1'b0, r.operand_a[7:0]} + {1'b0, r.operand_b[7:0]};
      word_sum = {1'b0, r.operand_a} + {1'b0, r.operand_b};
      case (r.op)
         OP_ADD8: begin
            lo = {1'b0, a8[3:0]} + {1'b0, r.operand_b[3:0]} + {4'b0, r.carry_in};
            hi = {1'b0, a8[7:4]} + {1'b0, r.operand_b[7:4]} + {4'b0, lo[4]};
            res.value = {8'h00, hi[3:0], lo[3:0]};
            res.flag_half_carry = lo[4];
            res.flag_carry = hi[4];
         end
         OP_SUB8: begin
            lo = {1'b0, a8[3:0]} - {1'b0, r.operand_b[3:0]} - {4'b0, r.carry_in};
            hi = {1'b0, a8[7:4]} - {1'b0, r.operand_b[7:4]} - {4'b0, lo[4]};
            res.value = {8'h00, hi[3:0], lo[3:0]};
            res.flag_subtract = 1'b1;
            res.flag_half_carry = lo[4];
            res.flag_carry = hi[4];
         end
         OP_ADD16_LO: begin
            lo = {1'b0, r.operand_a[3:0]} + {1'b0, r.operand_b[3:0]};
            res.value = word_sum[15:0];
            res.flag_half_carry = lo[4];
            res.flag_carry = byte_sum[8];
         end
         OP_ADD16_HI: begin
            lo = {1'b0, r.operand_a[11:8]} + {1'b0, r.operand_b[11:8]} + {4'b0, byte_sum[8]};
            hi = {1'b0, r.operand_a[15:12]} + {1'b0, r.operand_b[15:12]} + {4'b0, lo[4]};
            res.value = word_sum[15:0];
            res.flag_half_carry = lo[4];
            res.flag_carry = hi[4];
         end
         OP_SHIFT: begin
            res.value = r.direction ? {9'b0, a8[7:1]} : {8'h00, a8[6:0], 1'b0};
            res.flag_carry = r.direction ? a8[0] : a8[7];
         end
         OP_SRA: begin
            res.value = {8'h00, a8[7], a8[7:1]};
            res.flag_carry = a8[0];
         end
         OP_ROTATE: begin
            res.value = r.direction ? {8'h00, a8[0], a8[7:1]} : {8'h00, a8[6:0], a8[7]};
            res.flag_carry = r.direction ? a8[0] : a8[7];
         end
         default: begin
            res.value = r.direction ? {8'h00, r.carry_in, a8[7:1]}
                                    : {8'h00, a8[6:0], r.carry_in};
            res.flag_carry = r.direction ? a8[0] : a8[7];
         end
      endcase
      res.flag_zero = (res.value == '0);
      return res;
   endfunction

   function automatic req_item_type make_req(op_type op, logic [15:0] a, logic [15:0] b,
                                             logic cin, logic dir);
      req_item_type r;
      r.op = op;
      r.operand_a = a;
      r.operand_b = b;
      r.carry_in = cin;
      r.direction = dir;
      return r;
   endfunction

   // operands biased toward nibble and byte boundaries
   function automatic logic [15:0] rand_operand();
      logic [15:0] w;
      w = 16'($urandom);
      case ($urandom_range(0, 7))
         0: w = 16'h0000;
         1: w = 16'hFFFF;
         2: w = {8'h00, w[7:0]};
         3: begin
            for (int i = 0; i < 4; i++) begin
               case ($urandom_range(0, 4))
                  0: w[i*4 +: 4] = 4'h0;
                  1: w[i*4 +: 4] = 4'hF;
                  2: w[i*4 +: 4] = 4'h8;
                  3: w[i*4 +: 4] = 4'h7;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall)
            predicted_results.push_back(alu_compute(driven_req));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (alu_requests.size() != 0) begin
               next_req = alu_requests.pop_front();
               driven_req <= next_req;
               req_type <= next_req.op;
               req_operand_a <= next_req.operand_a;
               req_operand_b <= next_req.operand_b;
               req_carry_in <= next_req.carry_in;
               req_direction <= next_req.direction;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                            : $urandom_range(1, 16);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_kind'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 9) < 7);
            default:      rsp_stall <= mode_left[1];
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp.value = rsp_value;
         got_rsp.flag_zero = rsp_flag_zero;
         got_rsp.flag_subtract = rsp_flag_subtract;
         got_rsp.flag_half_carry = rsp_flag_half_carry;
         got_rsp.flag_carry = rsp_flag_carry;
         if (predicted_results.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: unexpected result value %h z%b n%b h%b c%b", $realtime,
                        got_rsp.value, got_rsp.flag_zero, got_rsp.flag_subtract,
                        got_rsp.flag_half_carry, got_rsp.flag_carry);
            fail_count++;
         end else begin
            want_rsp = predicted_results.pop_front();
            if (got_rsp.value !== want_rsp.value
                || got_rsp.flag_zero !== want_rsp.flag_zero
                || got_rsp.flag_subtract !== want_rsp.flag_subtract
                || got_rsp.flag_half_carry !== want_rsp.flag_half_carry
                || got_rsp.flag_carry !== want_rsp.flag_carry) begin
               if (fail_count < 10)
                  $display("%0t: mismatch expected %h z%b n%b h%b c%b got %h z%b n%b h%b c%b",
                           $realtime, want_rsp.value, want_rsp.flag_zero,
                           want_rsp.flag_subtract, want_rsp.flag_half_carry,
                           want_rsp.flag_carry, got_rsp.value, got_rsp.flag_zero,
                           got_rsp.flag_subtract, got_rsp.flag_half_carry,
                           got_rsp.flag_carry);
               fail_count++;
            end
         end
      end
   end

   initial begin
      // directed corners
      alu_requests.push_back(make_req(OP_ADD8, 16'h00FF, 16'h0000, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_ADD8, 16'hFF0F, 16'hAB01, 1'b0, 1'b1));
      alu_requests.push_back(make_req(OP_ADD8, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
      alu_requests.push_back(make_req(OP_ADD8, 16'h0000, 16'h0000, 1'b0, 1'b0));
      alu_requests.push_back(make_req(OP_SUB8, 16'h0000, 16'h0001, 1'b0, 1'b0));
      alu_requests.push_back(make_req(OP_SUB8, 16'h0010, 16'h0000, 1'b1, 1'b1));
      alu_requests.push_back(make_req(OP_SUB8, 16'h5A5A, 16'hA55A, 1'b0, 1'b0));
      alu_requests.push_back(make_req(OP_SUB8, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_ADD16_LO, 16'h00FF, 16'h0001, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_ADD16_LO, 16'h0F0F, 16'h0101, 1'b0, 1'b1));
      alu_requests.push_back(make_req(OP_ADD16_LO, 16'hFFFF, 16'h0001, 1'b1, 1'b1));
      alu_requests.push_back(make_req(OP_ADD16_HI, 16'hFFFF, 16'h0001, 1'b0, 1'b0));
      alu_requests.push_back(make_req(OP_ADD16_HI, 16'h0FFF, 16'h0001, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_ADD16_HI, 16'h8000, 16'h8000, 1'b0, 1'b1));
      alu_requests.push_back(make_req(OP_ADD16_HI, 16'h0000, 16'h0000, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_SHIFT, 16'hFF80, 16'hFFFF, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_SHIFT, 16'h0001, 16'h0000, 1'b1, 1'b1));
      alu_requests.push_back(make_req(OP_SRA, 16'h0081, 16'h1234, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_SRA, 16'h7F7F, 16'h0000, 1'b0, 1'b1));
      alu_requests.push_back(make_req(OP_ROTATE, 16'h0081, 16'h0000, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_ROTATE, 16'h0081, 16'hFFFF, 1'b0, 1'b1));
      alu_requests.push_back(make_req(OP_ROT_CARRY, 16'hFF00, 16'h0000, 1'b1, 1'b0));
      alu_requests.push_back(make_req(OP_ROT_CARRY, 16'h0000, 16'h0000, 1'b1, 1'b1));
      alu_requests.push_back(make_req(OP_ROT_CARRY, 16'h0080, 16'h0000, 1'b0, 1'b0));
      alu_requests.push_back(make_req(OP_ROT_CARRY, 16'h0001, 16'h0000, 1'b0, 1'b1));
      for (int i = 0; i < 1600; i++)
         alu_requests.push_back(make_req(op_type'($urandom_range(0, 7)), rand_operand(),
                                         rand_operand(), 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1))));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (alu_requests.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

[eight_bit_cpu_alu_with_flags.f]
+incdir+rtl
rtl/ebcalu_pkg.sv
rtl/eight_bit_cpu_alu_with_flags.sv
test/tb.sv
